@@ rtl/owsc_pkg.sv @@
// shared constants and types for the omni wheel speed command framer
package owsc_pkg;

  localparam int ANGLE_BITS     = 16;
  localparam int TRIG_FRAC_BITS = 15;

  localparam int IN_W    = 64;
  localparam int BYTE_W  = 8;
  localparam int VEL_W   = 16;
  localparam int HEAD_W  = 16;
  localparam int SPD_W   = 16;
  localparam int LEVER_W = 16;
  localparam logic [LEVER_W-1:0] LEVER_RESET = 16'd640;

  localparam int ANG_W = 32;
  localparam logic [ANG_W-1:0] SIXTY_DEG    = 32'h2AAA_AAAB;
  localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam int ZQ    = 30;
  localparam int Z_W   = ZQ + 1;
  localparam int K_W   = 31;
  localparam int NCOEF = 5;
  localparam logic [K_W-1:0] KCOEF [NCOEF] = '{
    31'd172272, 31'd5026996, 31'd85569305, 31'd693598668, 31'd1686629713
  };

  localparam int MAG_W     = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W    = TRIG_FRAC_BITS + 2;
  localparam int SH_W      = 2 * Z_W - (2 * ZQ - TRIG_FRAC_BITS);
  localparam int PROD_W    = TRIG_W + VEL_W;
  localparam int PAIR_W    = PROD_W + 1;
  localparam int LW_W      = LEVER_W + 1 + VEL_W;
  localparam int SPD_SCALE = 8;
  localparam int DIV_SH    = TRIG_FRAC_BITS + SPD_SCALE;
  localparam int SUM_W     = ((PAIR_W + SPD_SCALE > LW_W + TRIG_FRAC_BITS) ?
                              PAIR_W + SPD_SCALE : LW_W + TRIG_FRAC_BITS) + 1;
  localparam int QUO_W     = SUM_W - DIV_SH;

  localparam int NTRIG   = 6;
  localparam int ISSUE_W = $clog2(NTRIG);
  localparam logic [ISSUE_W-1:0] TRIG_SIN_AP = 3'd2;
  localparam logic [ISSUE_W-1:0] TRIG_COS_H  = 3'd5;

  localparam int NWHEEL  = 3;
  localparam int WHEEL_W = $clog2(NWHEEL);

  localparam int QDEPTH = 3;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam int FRAME_LEN = 17;
  localparam int POS_W     = $clog2(FRAME_LEN);
  localparam int HDR_LEN   = 6;
  localparam int HDR_IW    = $clog2(HDR_LEN);
  localparam int SPD_END   = HDR_LEN + 2 * NWHEEL;
  localparam int CSUM_POS  = FRAME_LEN - 1;
  localparam logic [BYTE_W-1:0] HDR [HDR_LEN] = '{
    8'h55, 8'hAA, 8'h38, 8'h0A, 8'h08, 8'h70
  };

  typedef logic signed [SPD_W-1:0] spd_t;

  typedef struct packed {
    spd_t [NWHEEL-1:0] spd;
  } wheel_set_t;

endpackage

@@ rtl/owsc_front.sv @@
// front end: accepts commands, runs the sine pipeline and forms the three wheel speeds
module owsc_front import owsc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [VEL_W-1:0]   vel_x_i,
  input  logic signed [VEL_W-1:0]   vel_y_i,
  input  logic signed [VEL_W-1:0]   turn_rate_i,
  input  logic [HEAD_W-1:0]         heading_i,
  input  logic [LEVER_W-1:0]        lever_i,
  input  logic [CNT_W-1:0]          q_count_i,
  output logic                      push_o,
  output wheel_set_t                push_data_o
);

  localparam int NSTG = 6;

  typedef struct packed {
    logic [ISSUE_W-1:0]      idx;
    logic                    neg;
    logic signed [VEL_W-1:0] vel;
    logic signed [VEL_W-1:0] w;
  } tag_t;

  logic                        accept;
  logic                        busy_q;
  logic [ISSUE_W-1:0]          issue_q;
  logic [CNT_W-1:0]            inflight_q;
  logic signed [VEL_W-1:0]     vx_q, vy_q, w_q;
  logic [ANGLE_BITS-1:0]       h_q;

  logic [ANG_W-1:0]            h32, am, ap, base, ang;
  logic [Z_W-1:0]              z_iss;
  tag_t                        tag_iss;

  logic [NSTG+1:0]             vld_q;
  tag_t                        tg [0:NSTG+1];
  logic [Z_W-1:0]              hz  [0:NSTG-1];
  logic [Z_W-1:0]              hz2 [1:NSTG-1];
  logic [K_W-1:0]              ht  [1:NSTG-1];
  logic [2*K_W-1:0]            hp  [2:NSTG-1];
  logic [K_W-1:0]              ht_next [2:NSTG-1];
  logic [2*Z_W-1:0]            sq_prod;
  logic [2*Z_W-1:0]            s_prod;
  logic [SH_W-1:0]             s_sh;
  logic [MAG_W-1:0]            mag_d, mag_q;
  logic signed [TRIG_W-1:0]    trig_s;
  logic signed [PROD_W-1:0]    prod_d, prod_q;

  logic signed [PROD_W-1:0]    part_q;
  logic signed [PAIR_W-1:0]    pair_q;
  logic signed [LW_W-1:0]      lw_q;
  logic                        pv_q;
  logic [WHEEL_W-1:0]          pw_q;
  logic signed [SUM_W-1:0]     total_q;
  logic                        tv_q;
  logic [WHEEL_W-1:0]          tw_q;
  logic signed [SUM_W-1:0]     biased;
  logic signed [QUO_W-1:0]     quo;
  spd_t                        sat;
  spd_t                        spd_q [NWHEEL];
  logic                        push_q;

  localparam logic signed [QUO_W-1:0] SAT_HI = QUO_W'(32767);
  localparam logic signed [QUO_W-1:0] SAT_LO = -QUO_W'(32768);

  assign in_ready_o = !busy_q &&
    ((CNT_W+1)'(inflight_q) + (CNT_W+1)'(q_count_i) < (CNT_W+1)'(QDEPTH));
  assign accept = in_valid_i && in_ready_o;

  // angle selection for the six sine evaluations
  always_comb begin
    h32 = ANG_W'(h_q) << (ANG_W - ANGLE_BITS);
    am  = SIXTY_DEG - h32;
    ap  = SIXTY_DEG + h32;
    case (issue_q[ISSUE_W-1:1])
      2'd0:    base = am;
      2'd1:    base = ap;
      default: base = h32;
    endcase
    ang = base + (issue_q[0] ? QUARTER_TURN : '0);
    if (ang[ZQ]) begin
      z_iss = (Z_W'(1) << ZQ) - Z_W'(ang[ZQ-1:0]);
    end else begin
      z_iss = Z_W'(ang[ZQ-1:0]);
    end
    tag_iss.idx = issue_q;
    tag_iss.neg = ang[ANG_W-1] ^ ((issue_q == TRIG_SIN_AP) || (issue_q == TRIG_COS_H));
    tag_iss.vel = issue_q[0] ? vy_q : vx_q;
    tag_iss.w   = w_q;
  end

  // horner steps
  always_comb begin
    sq_prod = (2*Z_W)'(hz[0]) * (2*Z_W)'(hz[0]);
    for (int k = 2; k < NSTG; k++) begin
      hp[k]      = (2*K_W)'(hz2[k-1]) * (2*K_W)'(ht[k-1]);
      ht_next[k] = KCOEF[k-1] - hp[k][ZQ +: K_W];
    end
    s_prod = (2*Z_W)'(hz[NSTG-1]) * (2*Z_W)'(ht[NSTG-1]);
    s_sh   = SH_W'(s_prod >> (2 * ZQ - TRIG_FRAC_BITS));
    if (s_sh > SH_W'(1 << TRIG_FRAC_BITS)) begin
      mag_d = MAG_W'(1 << TRIG_FRAC_BITS);
    end else begin
      mag_d = MAG_W'(s_sh);
    end
    trig_s = tg[NSTG].neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
    prod_d = PROD_W'(trig_s) * PROD_W'(tg[NSTG].vel);
  end

  // truncate toward zero, saturate
  always_comb begin
    biased = total_q + (total_q[SUM_W-1] ? SUM_W'((1 << DIV_SH) - 1) : '0);
    quo    = QUO_W'(biased >>> DIV_SH);
    if (quo > SAT_HI) begin
      sat = spd_t'(SAT_HI);
    end else if (quo < SAT_LO) begin
      sat = spd_t'(SAT_LO);
    end else begin
      sat = spd_t'(quo);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      issue_q    <= '0;
      inflight_q <= '0;
      vld_q      <= '0;
      pv_q       <= 1'b0;
      tv_q       <= 1'b0;
      push_q     <= 1'b0;
    end else begin
      if (accept) begin
        busy_q  <= 1'b1;
        issue_q <= '0;
      end else if (busy_q) begin
        issue_q <= issue_q + 1'b1;
        if (issue_q == ISSUE_W'(NTRIG - 1)) begin
          busy_q <= 1'b0;
        end
      end
      inflight_q <= inflight_q + CNT_W'(accept) - CNT_W'(push_q);
      vld_q      <= {vld_q[NSTG:0], busy_q};
      pv_q       <= vld_q[NSTG+1] && tg[NSTG+1].idx[0];
      tv_q       <= pv_q;
      push_q     <= tv_q && (tw_q == WHEEL_W'(NWHEEL - 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vx_q <= vel_x_i;
      vy_q <= vel_y_i;
      w_q  <= turn_rate_i;
      h_q  <= heading_i[ANGLE_BITS-1:0];
    end
    hz[0]  <= z_iss;
    tg[0]  <= tag_iss;
    hz[1]  <= hz[0];
    hz2[1] <= sq_prod[ZQ +: Z_W];
    ht[1]  <= KCOEF[0];
    tg[1]  <= tg[0];
    for (int k = 2; k < NSTG; k++) begin
      hz[k]  <= hz[k-1];
      hz2[k] <= hz2[k-1];
      ht[k]  <= ht_next[k];
      tg[k]  <= tg[k-1];
    end
    mag_q      <= mag_d;
    tg[NSTG]   <= tg[NSTG-1];
    prod_q     <= prod_d;
    tg[NSTG+1] <= tg[NSTG];
    if (vld_q[NSTG+1]) begin
      if (!tg[NSTG+1].idx[0]) begin
        part_q <= prod_q;
      end else begin
        pair_q <= PAIR_W'(part_q) + PAIR_W'(prod_q);
        lw_q   <= LW_W'($signed({1'b0, lever_i})) * LW_W'(tg[NSTG+1].w);
        pw_q   <= tg[NSTG+1].idx[ISSUE_W-1:1];
      end
    end
    total_q <= (SUM_W'(pair_q) <<< SPD_SCALE) + (SUM_W'(lw_q) <<< TRIG_FRAC_BITS);
    tw_q    <= pw_q;
    if (tv_q) begin
      spd_q[tw_q] <= sat;
    end
  end

  assign push_o = push_q;
  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      push_data_o.spd[i] = spd_q[i];
    end
  end

endmodule

@@ rtl/owsc_queue.sv @@
// small queue of finished wheel speed sets between front and back
module owsc_queue import owsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wheel_set_t       data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output wheel_set_t       head_o,
  output logic [CNT_W-1:0] count_o
);

  wheel_set_t        ent_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_inc(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_inc(rd_q);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign head_o  = ent_q[rd_q];
  assign count_o = cnt_q;

endmodule

@@ rtl/owsc_back.sv @@
// back end: serializes one speed set into a 17-byte frame with checksum
module owsc_back import owsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  wheel_set_t        q_head_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output logic [BYTE_W-1:0] m_data_o,
  output logic              m_last_o
);

  logic              ovld_q, olast_q;
  logic [BYTE_W-1:0] odata_q;
  logic [POS_W-1:0]  pos_q, k;
  logic [BYTE_W-1:0] csum_q, byte_d;
  logic              load, at_end;
  spd_t              sp;

  assign load   = q_valid_i && (!ovld_q || m_ready_i);
  assign at_end = (pos_q == POS_W'(CSUM_POS));
  assign pop_o  = load && at_end;

  always_comb begin
    k      = pos_q - POS_W'(HDR_LEN);
    sp     = q_head_i.spd[k[WHEEL_W:1]];
    byte_d = '0;
    if (pos_q < POS_W'(HDR_LEN)) begin
      byte_d = HDR[pos_q[HDR_IW-1:0]];
    end else if (pos_q < POS_W'(SPD_END)) begin
      byte_d = k[0] ? sp[BYTE_W-1:0] : sp[SPD_W-1:BYTE_W];
    end else if (at_end) begin
      byte_d = csum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
      pos_q  <= '0;
    end else begin
      if (!ovld_q || m_ready_i) begin
        ovld_q <= q_valid_i;
      end
      if (load) begin
        pos_q <= at_end ? '0 : pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      odata_q <= byte_d;
      olast_q <= at_end;
      csum_q  <= (pos_q == '0) ? byte_d : csum_q + byte_d;
    end
  end

  assign m_valid_o = ovld_q;
  assign m_data_o  = odata_q;
  assign m_last_o  = olast_q;

endmodule

@@ rtl/omni_wheel_speed_command_packet_top.sv @@
// top level of the three-wheel omni speed command framer
//
//  channel   dir  handshake               payload
//  s_axis    in   tvalid_i / tready_o     tdata_i: vel_x, vel_y, turn_rate, heading
//  m_axis    out  tvalid_o / tready_i     tdata_o: out_byte, tlast_o: last_byte
//  cfg       in   cfg_valid_i / cfg_ready_o  cfg_data_i: wheel_lever (Q8.8)
//
//  one command gives a 17-byte frame; sustained rate is set by the byte serializer,
//  one byte per cycle when m_axis_tready_i stays high
//  the first byte follows the command transfer through the sine pipeline, the
//  wheel sums and the queue; the front takes a new command once it has issued the six
//  sine evaluations of the last one, while the three-entry queue has room for it
//  reset sets wheel_lever to 2.5; the config port is always ready
//  a stall on m_axis holds the current byte and backs up through the queue
module omni_wheel_speed_command_packet_top import owsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [IN_W-1:0]   s_axis_tdata_i,   // vel_x, vel_y, turn_rate, heading
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [BYTE_W-1:0] m_axis_tdata_o,   // out_byte
  output logic              m_axis_tlast_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LEVER_W-1:0] cfg_data_i
);

  logic [LEVER_W-1:0] lever_q;
  logic               push, q_valid, pop;
  wheel_set_t         push_data, q_head;
  logic [CNT_W-1:0]   q_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lever_q <= LEVER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lever_q <= cfg_data_i;
    end
  end

  owsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .vel_x_i     (s_axis_tdata_i[VEL_W-1:0]),
    .vel_y_i     (s_axis_tdata_i[2*VEL_W-1:VEL_W]),
    .turn_rate_i (s_axis_tdata_i[3*VEL_W-1:2*VEL_W]),
    .heading_i   (s_axis_tdata_i[3*VEL_W+HEAD_W-1:3*VEL_W]),
    .lever_i     (lever_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  owsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (q_head),
    .count_o (q_count)
  );

  owsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (q_head),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .m_data_o  (m_axis_tdata_o),
    .m_last_o  (m_axis_tlast_o)
  );

endmodule

@@ rtl/owsc_checker.sv @@
// port-level checker for the framer, bound to the top level
module owsc_checker import owsc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [BYTE_W-1:0]  m_axis_tdata_o,
  input logic               m_axis_tlast_o
);

  logic              xfer;
  logic [POS_W-1:0]  pos_q;
  logic [BYTE_W-1:0] sum_q;

  assign xfer = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else if (xfer) begin
      pos_q <= (pos_q == POS_W'(CSUM_POS)) ? '0 : pos_q + 1'b1;
      sum_q <= (pos_q == '0) ? m_axis_tdata_o : sum_q + m_axis_tdata_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output changed while stalled");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> (m_axis_tlast_o == (pos_q == POS_W'(CSUM_POS))))
    else $error("tlast not on frame byte 17");

  a_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (pos_q < POS_W'(HDR_LEN)) |-> (m_axis_tdata_o == HDR[pos_q[HDR_IW-1:0]]))
    else $error("bad frame header byte");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (pos_q >= POS_W'(SPD_END)) && (pos_q < POS_W'(CSUM_POS)) |->
      (m_axis_tdata_o == '0))
    else $error("unused motor byte not zero");

  a_csum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && m_axis_tlast_o |-> (m_axis_tdata_o == sum_q))
    else $error("bad frame checksum");

endmodule

bind omni_wheel_speed_command_packet_top owsc_checker u_owsc_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench for the omni wheel framer: a directed command table, then random commands per lever
module testbench;
  import owsc_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 75;
  localparam int NDIRECTED   = 22;
  localparam int PRINT_CAP   = 100;

  localparam longint unsigned SIN_K1 = 64'd1686629713;
  localparam longint unsigned SIN_K3 = 64'd693598668;
  localparam longint unsigned SIN_K5 = 64'd85569305;
  localparam longint unsigned SIN_K7 = 64'd5026996;
  localparam longint unsigned SIN_K9 = 64'd172272;

  localparam logic [VEL_W-1:0]  EDGE_VALUES [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                                    16'h0001};
  localparam logic [HEAD_W-1:0] HEAD_PICKS  [6] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                                    16'h2AAB, 16'hFFFF};

  typedef struct packed {
    logic [HEAD_W-1:0]        heading;
    logic signed [VEL_W-1:0]  turn_rate;
    logic signed [VEL_W-1:0]  vel_y;
    logic signed [VEL_W-1:0]  vel_x;
  } speed_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_byte_t;

  // typed rows have zero velocity, so all three wheels carry the same speed
  typedef struct packed {
    logic signed [VEL_W-1:0]  vx;
    logic signed [VEL_W-1:0]  vy;
    logic signed [VEL_W-1:0]  w;
    logic [HEAD_W-1:0]        h;
    bit                       typed;
    logic signed [SPD_W-1:0]  speed;
  } directed_row_t;

  localparam directed_row_t DIRECTED_CMDS [NDIRECTED] = '{
    '{16'sd0,      16'sd0,      16'sd0,      16'h0000, 1'b1, 16'sd0},
    '{16'sd0,      16'sd0,      16'sd32767,  16'h1234, 1'b1, 16'sd32767},
    '{16'sd0,      16'sd0,      16'sh8000,   16'hFFFF, 1'b1, 16'sh8000},
    '{16'sd0,      16'sd0,      16'sd256,    16'h8000, 1'b1, 16'sd640},
    '{16'sd0,      16'sd0,      -16'sd256,   16'h4000, 1'b1, -16'sd640},
    '{16'sd0,      16'sd0,      16'sd1,      16'h0000, 1'b1, 16'sd2},
    '{16'sd0,      16'sd0,      -16'sd1,     16'h0000, 1'b1, -16'sd2},
    '{16'sd32767,  16'sd0,      16'sd0,      16'h0000, 1'b0, 16'sd0},
    '{16'sh8000,   16'sd0,      16'sd0,      16'h0000, 1'b0, 16'sd0},
    '{16'sd0,      16'sd32767,  16'sd0,      16'h0000, 1'b0, 16'sd0},
    '{16'sd0,      16'sh8000,   16'sd0,      16'h0000, 1'b0, 16'sd0},
    '{16'sd32767,  16'sd32767,  16'sd32767,  16'h0000, 1'b0, 16'sd0},
    '{16'sh8000,   16'sh8000,   16'sh8000,   16'h8000, 1'b0, 16'sd0},
    '{16'sd1000,   16'sd2000,   16'sd100,    16'h4000, 1'b0, 16'sd0},
    '{16'sd1000,   -16'sd2000,  -16'sd100,   16'hC000, 1'b0, 16'sd0},
    '{16'sd5000,   16'sd5000,   16'sd0,      16'h2AAB, 1'b0, 16'sd0},
    '{-16'sd5000,  16'sd3000,   16'sd50,     16'h1555, 1'b0, 16'sd0},
    '{16'sd12345,  -16'sd6789,  16'sd321,    16'hFFFF, 1'b0, 16'sd0},
    '{16'sd30000,  -16'sd30000, 16'sd0,      16'h2000, 1'b0, 16'sd0},
    '{16'sd32767,  16'sh8000,   16'sd12,     16'h6000, 1'b0, 16'sd0},
    '{-16'sd1,     -16'sd1,     -16'sd1,     16'h0001, 1'b0, 16'sd0},
    '{16'sd20000,  16'sd20000,  -16'sd20000, 16'hE000, 1'b0, 16'sd0}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [IN_W-1:0]     s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [BYTE_W-1:0]   m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LEVER_W-1:0]  cfg_data_i;

  logic [LEVER_W-1:0]  lever_setting;
  frame_byte_t         pending_frame_bytes [$];
  frame_byte_t         expected_byte;
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  int unsigned         bytes_seen = 0;
  bit                  idle_on;
  bit                  long_hold_req;

  omni_wheel_speed_command_packet_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) begin
      $display("cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // sin(pi/2 * z) in Q15 for z in Q30 over one quarter turn
  function automatic longint unsigned quarter_sine(input longint unsigned z);
    longint unsigned z2, t, s;
    z2 = (z * z) >> 30;
    t = SIN_K9;
    t = SIN_K7 - ((z2 * t) >> 30);
    t = SIN_K5 - ((z2 * t) >> 30);
    t = SIN_K3 - ((z2 * t) >> 30);
    t = SIN_K1 - ((z2 * t) >> 30);
    s = ((z * t) >> 30) >> (30 - TRIG_FRAC_BITS);
    if (s > (64'd1 << TRIG_FRAC_BITS)) begin
      s = 64'd1 << TRIG_FRAC_BITS;
    end
    return s;
  endfunction

  function automatic longint trig_sin(input logic [ANG_W-1:0] a);
    longint mag;
    if (a[30]) begin
      mag = quarter_sine(64'h4000_0000 - a[29:0]);
    end else begin
      mag = quarter_sine(a[29:0]);
    end
    return a[31] ? -mag : mag;
  endfunction

  function automatic longint trig_cos(input logic [ANG_W-1:0] a);
    logic [ANG_W-1:0] b;
    b = a + QUARTER_TURN;
    return trig_sin(b);
  endfunction

  function automatic logic [SPD_W-1:0] wheel_speed(input longint sx, cy, vx, vy, lw);
    longint acc, q;
    acc = (sx * vx + cy * vy) * 256 + lw * (longint'(1) << TRIG_FRAC_BITS);
    q = acc / (longint'(1) << (TRIG_FRAC_BITS + 8));
    if (q > 32767) begin
      q = 32767;
    end
    if (q < -32768) begin
      q = -32768;
    end
    return q[SPD_W-1:0];
  endfunction

  function automatic logic [NWHEEL-1:0][SPD_W-1:0] wheel_speeds_for(input speed_cmd_t cmd);
    logic [ANG_W-1:0] h32, am, ap;
    longint vx, vy, lw;
    logic [NWHEEL-1:0][SPD_W-1:0] speeds;
    vx = cmd.vel_x;
    vy = cmd.vel_y;
    lw = longint'(lever_setting) * cmd.turn_rate;
    h32 = {cmd.heading, 16'h0000};
    am = SIXTY_DEG - h32;
    ap = SIXTY_DEG + h32;
    speeds[0] = wheel_speed(trig_sin(am), trig_cos(am), vx, vy, lw);
    speeds[1] = wheel_speed(-trig_sin(ap), trig_cos(ap), vx, vy, lw);
    speeds[2] = wheel_speed(trig_sin(h32), -trig_cos(h32), vx, vy, lw);
    return speeds;
  endfunction

  function automatic void queue_frame(input logic [NWHEEL-1:0][SPD_W-1:0] speeds);
    logic [BYTE_W-1:0] frame [FRAME_LEN];
    logic [BYTE_W-1:0] csum;
    csum = '0;
    for (int i = 0; i < HDR_LEN; i++) begin
      frame[i] = HDR[i];
    end
    for (int k = 0; k < NWHEEL; k++) begin
      frame[HDR_LEN + 2 * k]     = speeds[k][15:8];
      frame[HDR_LEN + 2 * k + 1] = speeds[k][7:0];
    end
    for (int i = SPD_END; i < CSUM_POS; i++) begin
      frame[i] = '0;
    end
    for (int i = 0; i < CSUM_POS; i++) begin
      csum += frame[i];
      pending_frame_bytes.push_back('{frame[i], 1'b0});
    end
    pending_frame_bytes.push_back('{csum, 1'b1});
  endfunction

  function automatic logic [VEL_W-1:0] random_speed_field();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      return EDGE_VALUES[$urandom_range(0, 4)];
    end
    if (sel < 5) begin
      return 16'($urandom_range(0, 4095) - 2048);
    end
    return 16'($urandom);
  endfunction

  function automatic speed_cmd_t random_cmd();
    speed_cmd_t c;
    c.vel_x = random_speed_field();
    c.vel_y = random_speed_field();
    c.turn_rate = random_speed_field();
    c.heading = ($urandom_range(0, 7) == 0) ? HEAD_PICKS[$urandom_range(0, 5)] : 16'($urandom);
    return c;
  endfunction

  task automatic send_command(input speed_cmd_t c);
    s_axis_tdata_i <= c;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (s_axis_tready_o !== 1'b1);
  endtask

  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic drain(input int settle);
    while (pending_frame_bytes.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_lever(input logic [LEVER_W-1:0] value);
    drain(4);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    lever_setting = value;
  endtask

  task automatic run_random(input int count);
    speed_cmd_t c;
    for (int i = 0; i < count; i++) begin
      c = random_cmd();
      send_command(c);
      queue_frame(wheel_speeds_for(c));
      sender_gap();
    end
    s_axis_tvalid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_frame_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", m_axis_tdata_o));
      end else begin
        expected_byte = pending_frame_bytes.pop_front();
        if (m_axis_tdata_o !== expected_byte.data) begin
          report_mismatch($sformatf("byte %0d: data %02h, want %02h", bytes_seen,
                                    m_axis_tdata_o, expected_byte.data));
        end
        if (m_axis_tlast_o !== expected_byte.last) begin
          report_mismatch($sformatf("byte %0d: tlast %b, want %b", bytes_seen,
                                    m_axis_tlast_o, expected_byte.last));
        end
      end
      bytes_seen++;
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    speed_cmd_t cmd;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    lever_setting = LEVER_RESET;
    idle_on = 1'b1;
    long_hold_req = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDIRECTED; i++) begin
      cmd.vel_x = DIRECTED_CMDS[i].vx;
      cmd.vel_y = DIRECTED_CMDS[i].vy;
      cmd.turn_rate = DIRECTED_CMDS[i].w;
      cmd.heading = DIRECTED_CMDS[i].h;
      send_command(cmd);
      if (DIRECTED_CMDS[i].typed) begin
        queue_frame({NWHEEL{DIRECTED_CMDS[i].speed}});
      end else begin
        queue_frame(wheel_speeds_for(cmd));
      end
      sender_gap();
    end
    run_random(PHASE_ITEMS);

    write_lever(16'h0000);
    run_random(PHASE_ITEMS);
    write_lever(16'hFFFF);
    long_hold_req = 1'b1;
    run_random(PHASE_ITEMS);
    write_lever(16'h0001);
    run_random(PHASE_ITEMS);
    write_lever(16'($urandom_range(0, 65535)));
    run_random(PHASE_ITEMS);
    // last stretch runs at full rate on both sides
    write_lever(LEVER_RESET);
    idle_on = 1'b0;
    run_random(PHASE_ITEMS);

    drain(30);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
